// ===== design/xmk_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the CRC-16 byte update for the XMODEM-1K receiver.
// Depends on nothing; imported by every module of the block.
package xmk_pkg;

  localparam int BLOCK_BYTES = 1024;
  localparam int CNT_W       = $clog2(BLOCK_BYTES);
  localparam int ADDR_W      = 26;
  localparam int TDATA_IN_W  = 8;
  localparam int TUSER_IN_W  = 2;
  localparam int TDATA_OUT_W = 40;
  localparam int TUSER_OUT_W = 4;

  localparam logic [1:0] FUNC_BYTE    = 2'd0;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd1;
  localparam logic [1:0] FUNC_START   = 2'd2;

  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CRC = 8'h43;

  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic [6:0] {
    PH_IDLE       = 7'b0000001,
    PH_HEADER     = 7'b0000010,
    PH_NUMBER     = 7'b0000100,
    PH_COMPLEMENT = 7'b0001000,
    PH_DATA       = 7'b0010000,
    PH_CRC_HI     = 7'b0100000,
    PH_CRC_LO     = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic              session_done;
    logic              block_discard;
    logic              block_commit;
    logic [ADDR_W-1:0] flash_address;
    logic [7:0]        out_byte;
    logic              out_kind;
  } res_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== design/xmk_engine.sv =====
`timescale 1ns / 1ps
// Protocol engine: session phase, block counters, running CRC and result decode.
// Depends on xmk_pkg.
module xmk_engine (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  input  logic                      consume,
  input  logic [1:0]                func,
  input  logic [7:0]                rx_byte,
  input  logic [xmk_pkg::ADDR_W-1:0] base_address,
  output logic                      has_res,
  output xmk_pkg::res_t             res
);
  import xmk_pkg::*;

  phase_t            phase, phase_next;
  logic [7:0]        block_number, block_number_next;
  logic [CNT_W-1:0]  byte_count, byte_count_next;
  logic [15:0]       running_crc, running_crc_next;
  logic [7:0]        crc_high_byte, crc_high_byte_next;
  logic [ADDR_W-1:0] write_address, write_address_next;
  logic [8:0]        num_sum;

  assign num_sum = {1'b0, block_number} + {1'b0, rx_byte};

  always_comb begin
    phase_next         = phase;
    block_number_next  = block_number;
    byte_count_next    = byte_count;
    running_crc_next   = running_crc;
    crc_high_byte_next = crc_high_byte;
    write_address_next = write_address;
    has_res            = 1'b0;
    res                = '0;
    res.out_kind       = KIND_REPLY;
    if (item_valid) begin
      case (func)
        FUNC_START: begin
          write_address_next = base_address;
          block_number_next  = '0;
          byte_count_next    = '0;
          running_crc_next   = '0;
          crc_high_byte_next = '0;
          phase_next         = PH_HEADER;
          has_res            = 1'b1;
          res.out_byte       = CH_CRC;
        end
        FUNC_TIMEOUT: begin
          if (phase == PH_HEADER) begin
            has_res      = 1'b1;
            res.out_byte = CH_CRC;
          end else if (phase != PH_IDLE) begin
            phase_next        = PH_HEADER;
            has_res           = 1'b1;
            res.out_byte      = CH_NAK;
            res.block_discard = 1'b1;
          end
        end
        FUNC_BYTE: begin
          case (phase)
            PH_IDLE: begin
            end
            PH_HEADER: begin
              if (rx_byte == CH_EOT) begin
                phase_next       = PH_IDLE;
                has_res          = 1'b1;
                res.out_byte     = CH_ACK;
                res.session_done = 1'b1;
              end else if (rx_byte == CH_STX) begin
                phase_next = PH_NUMBER;
              end else begin
                has_res      = 1'b1;
                res.out_byte = CH_NAK;
              end
            end
            PH_NUMBER: begin
              block_number_next = rx_byte;
              phase_next        = PH_COMPLEMENT;
            end
            PH_COMPLEMENT: begin
              if (num_sum != 9'h0FF) begin
                phase_next        = PH_HEADER;
                has_res           = 1'b1;
                res.out_byte      = CH_NAK;
                res.block_discard = 1'b1;
              end else begin
                byte_count_next  = '0;
                running_crc_next = '0;
                phase_next       = PH_DATA;
              end
            end
            PH_DATA: begin
              running_crc_next  = crc_step(running_crc, rx_byte);
              has_res           = 1'b1;
              res.out_kind      = KIND_DATA;
              res.out_byte      = rx_byte;
              res.flash_address = write_address + ADDR_W'(byte_count);
              if (byte_count == CNT_W'(BLOCK_BYTES - 1)) begin
                byte_count_next = '0;
                phase_next      = PH_CRC_HI;
              end else begin
                byte_count_next = byte_count + 1'b1;
              end
            end
            PH_CRC_HI: begin
              crc_high_byte_next = rx_byte;
              phase_next         = PH_CRC_LO;
            end
            PH_CRC_LO: begin
              phase_next = PH_HEADER;
              has_res    = 1'b1;
              if ({crc_high_byte, rx_byte} == running_crc) begin
                write_address_next = write_address + ADDR_W'(BLOCK_BYTES);
                res.out_byte       = CH_ACK;
                res.block_commit   = 1'b1;
              end else begin
                res.out_byte      = CH_NAK;
                res.block_discard = 1'b1;
              end
            end
            default: begin
              phase_next = PH_IDLE;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      block_number  <= '0;
      byte_count    <= '0;
      running_crc   <= '0;
      crc_high_byte <= '0;
      write_address <= '0;
    end else if (consume) begin
      phase         <= phase_next;
      block_number  <= block_number_next;
      byte_count    <= byte_count_next;
      running_crc   <= running_crc_next;
      crc_high_byte <= crc_high_byte_next;
      write_address <= write_address_next;
    end
  end

  a_phase_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(phase))
    else $error("phase register is not one-hot");

  a_block_end: assert property (@(posedge clk) disable iff (rst)
    (consume && phase == PH_DATA && func == FUNC_BYTE &&
     byte_count == CNT_W'(BLOCK_BYTES - 1)) |=> (phase == PH_CRC_HI))
    else $error("last data byte did not move to the CRC trailer");

  a_commit_advance: assert property (@(posedge clk) disable iff (rst)
    (consume && has_res && res.block_commit) |=>
    (write_address == $past(write_address) + ADDR_W'(BLOCK_BYTES)))
    else $error("commit did not advance the write address");

endmodule

// ===== design/xmk_out_reg.sv =====
`timescale 1ns / 1ps
// Result register on the master-side stream; holds a beat until it is taken.
// Depends on xmk_pkg.
module xmk_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  xmk_pkg::res_t res,
  output logic          out_free,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output xmk_pkg::res_t res_q
);
  import xmk_pkg::*;

  logic o_valid;

  assign out_free      = !o_valid || m_axis_tready;
  assign m_axis_tvalid = o_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (load) begin
      o_valid <= 1'b1;
    end else if (m_axis_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

endmodule

// ===== design/xmodem_1k_crc_receiver.sv =====
`timescale 1ns / 1ps
// Top level of the XMODEM-1K CRC-16 receiver: input register, engine, result register.
// Depends on xmk_pkg, xmk_engine and xmk_out_reg.
//
// Slave stream: one beat per event; tuser carries the event code (received
// byte, timeout, start session) and tdata the received byte.
// Master stream: at most one beat per event, either a staged data byte with
// its flash address or a reply byte for the host with commit, discard and
// done flags.
// cfg_we/cfg_data write the base flash address; it is taken at session start.
// Every event is first held in an input register and then decoded into the
// result register. One beat is taken every cycle unless a result is waiting
// for a full result register; the only limit is the single result register,
// which frees up in the same cycle that its beat is taken.
// A stalled master side holds the result and back-pressures the slave side
// once the input register also holds an event that produces a result.
// Reset clears the session to idle, the base address to zero and both
// registers to empty.
module xmodem_1k_crc_receiver (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [xmk_pkg::TDATA_IN_W-1:0]  s_axis_tdata,   // rx_byte
  input  logic [xmk_pkg::TUSER_IN_W-1:0]  s_axis_tuser,   // func
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [xmk_pkg::TDATA_OUT_W-1:0] m_axis_tdata,   // out_byte, flash_address, zero pad
  output logic [xmk_pkg::TUSER_OUT_W-1:0] m_axis_tuser,   // out_kind, block_commit,
                                                          // block_discard, session_done
  input  logic                            cfg_we,
  input  logic [xmk_pkg::ADDR_W-1:0]      cfg_data
);
  import xmk_pkg::*;

  logic              in_valid;
  logic [1:0]        in_func;
  logic [7:0]        in_byte;
  logic [ADDR_W-1:0] base_address;
  logic              has_res;
  logic              out_free;
  logic              consume;
  res_t              res;
  res_t              res_q;

  assign consume       = in_valid && (out_free || !has_res);
  assign s_axis_tready = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_func <= s_axis_tuser;
      in_byte <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
    end else if (cfg_we) begin
      base_address <= cfg_data;
    end
  end

  xmk_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (in_valid),
    .consume      (consume),
    .func         (in_func),
    .rx_byte      (in_byte),
    .base_address (base_address),
    .has_res      (has_res),
    .res          (res)
  );

  xmk_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .load          (consume && has_res),
    .res           (res),
    .out_free      (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .res_q         (res_q)
  );

  assign m_axis_tdata = {(TDATA_OUT_W - ADDR_W - 8)'(0), res_q.flash_address, res_q.out_byte};
  assign m_axis_tuser = {res_q.session_done, res_q.block_discard,
                         res_q.block_commit, res_q.out_kind};

  a_data_no_flags: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res_q.out_kind == KIND_DATA) |->
    !(res_q.block_commit || res_q.block_discard || res_q.session_done))
    else $error("flag set on a staged data beat");

  a_commit_is_ack: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (res_q.block_commit || res_q.session_done)) |->
    (res_q.out_kind == KIND_REPLY && res_q.out_byte == CH_ACK))
    else $error("commit or done without ACK reply");

  a_reply_no_addr: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res_q.out_kind == KIND_REPLY) |-> (res_q.flash_address == '0))
    else $error("reply beat carries a flash address");

endmodule
